// ===== src/wmd_pkg.sv =====
// Shared widths and defaults for the window mean and deviation block.
// No dependencies; the interfaces, the window block and the checker import this package.
package wmd_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int STAMP_W    = 32;
	localparam int MEAN_W     = 20;
	localparam int DEV_OUT_W  = 24;
	localparam int WINDOW_DEF = 16;

endpackage

// ===== src/wmd_if.sv =====
// Valid/ready channel interfaces for sample words and result words.
// Depends on wmd_pkg for field widths.
interface wmd_in_if import wmd_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic        [STAMP_W-1:0]  stamp;

	modport source (output valid, output sample, output stamp, input ready);
	modport sink   (input valid, input sample, input stamp, output ready);
endinterface

interface wmd_out_if import wmd_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic        [STAMP_W-1:0]   stamp_out;
	logic signed [MEAN_W-1:0]    mean_scaled;
	logic        [DEV_OUT_W-1:0] deviation_scaled;

	modport source (output valid, output stamp_out, output mean_scaled,
		output deviation_scaled, input ready);
	modport sink   (input valid, input stamp_out, input mean_scaled,
		input deviation_scaled, output ready);
endinterface

// ===== src/wmd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/window_mean_and_deviation.sv =====
// Moving window mean and mean absolute deviation over WINDOW samples.
// An accepted word is registered into stage 1 while its line slot is read; the update
// registers its result word and writes the slot. One word per cycle unless results stall.
// Reset (arst_n low): running sums, slot counter and valid flags clear at once; line
// entries not yet written since reset read as zero through a fill flag, no clearing pass.
module window_mean_and_deviation import wmd_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input logic       clk,
	input logic       arst_n,
	wmd_in_if.sink    samples,
	wmd_out_if.source results
);

	localparam int LOG_W  = $clog2(WINDOW);
	localparam int SUM_W  = SAMPLE_W + LOG_W;
	localparam int DIFF_W = SUM_W + 1;
	localparam int DEV_W  = SAMPLE_W + 1 + 2 * LOG_W;
	localparam int LINE_W = SAMPLE_W + SUM_W;

	logic [LOG_W-1:0] slot_q;
	logic             filled_q;

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic        [STAMP_W-1:0]  stamp_s1;
	logic        [LOG_W-1:0]    slot_s1;
	logic                       old_ok_s1;
	logic        [LINE_W-1:0]   line_s1;

	logic signed [SUM_W-1:0] sum_q;
	logic        [DEV_W-1:0] dev_q;

	logic                        out_valid_q;
	logic        [STAMP_W-1:0]   stamp_out_q;
	logic signed [MEAN_W-1:0]    mean_q;
	logic        [DEV_OUT_W-1:0] dev_out_q;

	logic in_acc;
	logic adv_s1;

	logic signed [SAMPLE_W-1:0]        old_x;
	logic signed [SUM_W-1:0]           old_s;
	logic signed [SUM_W-1:0]           new_sum;
	logic signed [DIFF_W-1:0]          gain_d;
	logic signed [DIFF_W-1:0]          loss_d;
	logic        [DIFF_W-1:0]          gain;
	logic        [DIFF_W-1:0]          loss;
	logic        [DEV_W-1:0]           dev_next;
	logic        [SUM_W+MEAN_W-1:0]    mean_ext;
	logic        [DEV_W+DEV_OUT_W-1:0] dev_ext;

	assign adv_s1          = valid_s1 && (!out_valid_q || results.ready);
	assign samples.ready   = !valid_s1 || !out_valid_q || results.ready;
	assign in_acc          = samples.valid && samples.ready;

	// Departing entry: zero until the line has wrapped once since reset.
	assign old_x = old_ok_s1 ? $signed(line_s1[LINE_W-1:SUM_W]) : '0;
	assign old_s = old_ok_s1 ? $signed(line_s1[SUM_W-1:0]) : '0;

	assign new_sum = sum_q + SUM_W'(sample_s1) - SUM_W'(old_x);
	assign gain_d  = (DIFF_W'(sample_s1) <<< LOG_W) - DIFF_W'(new_sum);
	assign loss_d  = (DIFF_W'(old_x) <<< LOG_W) - DIFF_W'(old_s);
	assign gain    = gain_d[DIFF_W-1] ? DIFF_W'(-gain_d) : DIFF_W'(gain_d);
	assign loss    = loss_d[DIFF_W-1] ? DIFF_W'(-loss_d) : DIFF_W'(loss_d);
	assign dev_next = dev_q + DEV_W'(gain) - DEV_W'(loss);

	assign mean_ext = {{MEAN_W{new_sum[SUM_W-1]}}, new_sum};
	assign dev_ext  = {{DEV_OUT_W{1'b0}}, dev_next};

	wmd_ram #(
		.WIDTH(LINE_W),
		.DEPTH(WINDOW)
	) u_line (
		.clk  (clk),
		.we   (adv_s1),
		.waddr(slot_s1),
		.wdata({sample_s1, new_sum}),
		.re   (in_acc),
		.raddr(slot_q),
		.rdata(line_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			filled_q    <= 1'b0;
			valid_s1    <= 1'b0;
			sum_q       <= '0;
			dev_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				slot_q <= slot_q + 1'b1;
				if (slot_q == LOG_W'(WINDOW - 1)) begin
					filled_q <= 1'b1;
				end
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				sum_q       <= new_sum;
				dev_q       <= dev_next;
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: hold unless a word moves in.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1 <= samples.sample;
			stamp_s1  <= samples.stamp;
			slot_s1   <= slot_q;
			old_ok_s1 <= filled_q;
		end
		if (adv_s1) begin
			stamp_out_q <= stamp_s1;
			mean_q      <= $signed(mean_ext[MEAN_W-1:0]);
			dev_out_q   <= dev_ext[DEV_OUT_W-1:0];
		end
	end

	assign results.valid            = out_valid_q;
	assign results.stamp_out        = stamp_out_q;
	assign results.mean_scaled      = mean_q;
	assign results.deviation_scaled = dev_out_q;

endmodule

// ===== src/wmd_checker.sv =====
// Port-level assertions for window_mean_and_deviation, attached by bind.
// Depends on wmd_pkg for field widths.
module wmd_checker import wmd_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [STAMP_W-1:0]   out_stamp,
	input logic [MEAN_W-1:0]    out_mean,
	input logic [DEV_OUT_W-1:0] out_dev
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_stamp)
			&& $stable(out_mean) && $stable(out_dev))
		else $error("result word changed while stalled");

	// Input backpressure only comes from a stalled output.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with output free");

	// A fresh result word follows an accepted word.
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result word without source word");

	// No stall downstream: an accepted word shows up as a result word.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("result word missing");

endmodule

bind window_mean_and_deviation wmd_checker u_wmd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (samples.valid),
	.in_ready (samples.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_stamp(results.stamp_out),
	.out_mean (results.mean_scaled),
	.out_dev  (results.deviation_scaled)
);
